### sv/rbt_pkg.sv
package rbt_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int MAX_XFER = 64;

  localparam int LEN_W = 7;
  localparam int SIZE_W = 11;
  localparam int CFG_ADDR_W = 3;

  localparam logic [SIZE_W-1:0] FIFO_SIZE_RST = 11'd1024;

  localparam logic REG_FIFO_SIZE = 1'b0;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NODATA = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  typedef struct packed {
    logic accept;
    logic send_data;
    logic send_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic wr_result;
    logic rd_run;
    logic run_last;
  } dp_stat_t;

endpackage

### sv/rbt_in_if.sv
interface rbt_in_if;
  import rbt_pkg::*;

  logic valid;
  logic ready;
  logic action;
  logic [LEN_W-1:0] transfer_length;
  logic [7:0] data_byte;

  modport source (output valid, output action, output transfer_length, output data_byte,
                  input ready);
  modport sink (input valid, input action, input transfer_length, input data_byte,
                output ready);
endinterface

### sv/rbt_out_if.sv
interface rbt_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [7:0] read_byte;
  logic read_valid;
  logic last_of_run;

  modport source (output valid, output status, output read_byte, output read_valid,
                  output last_of_run, input ready);
  modport sink (input valid, input status, input read_byte, input read_valid,
                input last_of_run, output ready);
endinterface

### sv/ring_buffer_block_transfer.sv
// Write bytes: one accepted per cycle unless a result is pending; the last byte gives its status in the cycle after.
// Read request: each emitted byte takes a registered store read, then the output
//   transfer, which waits for out_ready; the byte store has a single read port.
// Status-only results appear the cycle after the request and hold until taken.
// Synchronous reset clears indices and control; store contents stay undefined.
module ring_buffer_block_transfer
  import rbt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  rbt_in_if.sink                in_ch,
  rbt_out_if.source             out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  rbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbt_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (paddr),
    .cfg_wdata   (pwdata),
    .cfg_rdata   (prdata),
    .in_action   (in_ch.action),
    .in_len      (in_ch.transfer_length),
    .in_data     (in_ch.data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .status      (out_ch.status),
    .read_byte   (out_ch.read_byte),
    .read_valid  (out_ch.read_valid),
    .last_of_run (out_ch.last_of_run)
  );

endmodule

### sv/rbt_ctrl.sv
module rbt_ctrl
  import rbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RESP  = 4'b0010,
    S_FETCH = 4'b0100,
    S_SEND  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_action == ACT_READ) begin
            state_next = stat.rd_run ? S_FETCH : S_RESP;
          end else if (stat.wr_result) begin
            state_next = S_RESP;
          end
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      S_FETCH: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        out_valid = 1'b1;
        cmd.send_data = 1'b1;
        if (out_ready) begin
          cmd.send_step = 1'b1;
          state_next = stat.run_last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/rbt_datapath.sv
module rbt_datapath
  import rbt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_wdata,
  output logic [31:0]           cfg_rdata,
  input  logic                  in_action,
  input  logic [LEN_W-1:0]      in_len,
  input  logic [7:0]            in_data,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  output logic [1:0]            status,
  output logic [7:0]            read_byte,
  output logic                  read_valid,
  output logic                  last_of_run
);

  localparam int IW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = (SW > LEN_W) ? SW : LEN_W;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata;
  logic [SIZE_W-1:0] fifo_size;
  logic [IW-1:0]     read_index;
  logic [IW-1:0]     write_index;
  logic [IW-1:0]     pend_pos;
  logic [LEN_W-1:0]  rem;
  logic              rejected;
  logic [1:0]        resp_status;
  logic [LEN_W-1:0]  run_cnt;

  logic [SW-1:0]     ring_sz;
  logic [SW-1:0]     used;
  logic [SW-1:0]     free_slots;
  logic              first;
  logic              cur_rej;
  logic [IW-1:0]     cur_pos;
  logic [LEN_W-1:0]  rem_dec;
  logic              rd_fail;
  logic              wr_acc;
  logic              rd_acc;
  logic              mem_we;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] pos,
                                              input logic [SW-1:0] sz);
    logic [SW-1:0] inc;
    inc = SW'(pos) + SW'(1);
    return (inc >= sz) ? '0 : IW'(inc);
  endfunction

  always_comb begin
    if (fifo_size < SIZE_W'(2)) begin
      ring_sz = SW'(2);
    end else if (32'(fifo_size) > 32'(DEPTH)) begin
      ring_sz = SW'(DEPTH);
    end else begin
      ring_sz = SW'(fifo_size);
    end
  end

  assign used = (write_index >= read_index) ? SW'(write_index) - SW'(read_index)
                                            : SW'(write_index) + ring_sz - SW'(read_index);
  assign free_slots = ring_sz - SW'(1) - used;

  assign first = (rem == '0);
  assign cur_rej = first ? ((in_len > LEN_W'(MAX_XFER)) || (CW'(in_len) > CW'(free_slots)))
                         : rejected;
  assign cur_pos = first ? write_index : pend_pos;
  assign rem_dec = (first ? in_len : rem) - LEN_W'(1);

  assign rd_fail = (in_len > LEN_W'(MAX_XFER)) || (CW'(in_len) > CW'(used));

  assign stat.wr_result = first ? (in_len <= LEN_W'(1)) : (rem == LEN_W'(1));
  assign stat.rd_run = !rd_fail && (in_len != '0);
  assign stat.run_last = (run_cnt == LEN_W'(1));

  assign wr_acc = cmd.accept && (in_action == ACT_WRITE) && !(first && in_len == '0);
  assign rd_acc = cmd.accept && (in_action == ACT_READ);
  assign mem_we = wr_acc && !cur_rej;

  always_ff @(posedge clk) begin
    if (mem_we) mem[cur_pos] <= in_data;
    rdata <= mem[read_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_size <= FIFO_SIZE_RST;
      read_index <= '0;
      write_index <= '0;
      pend_pos <= '0;
      rem <= '0;
      rejected <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_addr[2] == REG_FIFO_SIZE) begin
        fifo_size <= cfg_wdata[SIZE_W-1:0];
        read_index <= '0;
        write_index <= '0;
        pend_pos <= '0;
        rem <= '0;
        rejected <= 1'b0;
      end
    end else begin
      if (wr_acc) begin
        rem <= rem_dec;
        if (!cur_rej) pend_pos <= ring_next(cur_pos, ring_sz);
        if (rem_dec == '0) begin
          rejected <= 1'b0;
          if (!cur_rej) write_index <= ring_next(cur_pos, ring_sz);
        end else begin
          rejected <= cur_rej;
        end
      end
      if (cmd.send_step) read_index <= ring_next(read_index, ring_sz);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_acc) begin
      resp_status <= rd_fail ? ST_NODATA : ST_OK;
      run_cnt <= in_len;
    end else if (cmd.accept) begin
      resp_status <= cur_rej ? ST_NOSPACE : ST_OK;
    end else if (cmd.send_step) begin
      run_cnt <= run_cnt - LEN_W'(1);
    end
  end

  assign cfg_rdata = (cfg_addr[2] == REG_FIFO_SIZE) ? 32'(fifo_size) : '0;

  assign status = cmd.send_data ? ST_OK : resp_status;
  assign read_byte = cmd.send_data ? rdata : 8'd0;
  assign read_valid = cmd.send_data;
  assign last_of_run = cmd.send_data ? stat.run_last : 1'b1;

endmodule

### sv/rbt_checker.sv
module rbt_checker
  import rbt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            status,
  input logic [7:0]            read_byte,
  input logic                  read_valid,
  input logic                  last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_byte)
      && $stable(read_valid) && $stable(last_of_run))
    else $error("stalled result changed");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> last_of_run && read_byte == 8'd0 && status != 2'd3)
    else $error("malformed status result");

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> status == ST_OK)
    else $error("data byte with error status");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[2] == REG_FIFO_SIZE
      |=> prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0]) || paddr[2] != REG_FIFO_SIZE)
    else $error("ring size register not updated");

endmodule

bind ring_buffer_block_transfer rbt_checker u_rbt_checker (
  .clk         (clk),
  .rst         (rst),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .read_byte   (out_ch.read_byte),
  .read_valid  (out_ch.read_valid),
  .last_of_run (out_ch.last_of_run)
);

### dv/ring_buffer_block_transfer_tb.sv
module ring_buffer_block_transfer_tb;
  import rbt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_TOTAL = 270;

  typedef struct {
    logic             action;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    int               gap;
    bit               drain;
  } link_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] rbyte;
    logic       rvalid;
    logic       last;
  } ring_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rbt_in_if in_ch ();
  rbt_out_if out_ch ();

  ring_buffer_block_transfer dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  link_item_t link_queue[$];
  ring_result_t ring_results_due[$];
  int results_due;
  int failures;
  int cycle_count;
  int items_queued;
  bit quiet;
  bit hold_next;

  // stimulus-side fill tracking, used only to shape lengths
  int gen_ring;
  int gen_held;

  // predictor state
  logic [7:0] ring_bytes [DEPTH_DEF];
  int rd_idx;
  int wr_idx;
  int pend_pos;
  int bytes_left;
  bit pend_rejected;
  logic [SIZE_W-1:0] size_reg;

  // driver state
  link_item_t cur_item;
  bit have_item;
  int idle_left;
  int stall_left;

  function automatic int clamp_ring(input logic [SIZE_W-1:0] sz);
    if (sz < 2) return 2;
    if (sz > DEPTH_DEF) return DEPTH_DEF;
    return int'(sz);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      have_item = 1'b0;
      idle_left = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (!have_item && link_queue.size() > 0) begin
        cur_item = link_queue.pop_front();
        have_item = 1'b1;
        idle_left = cur_item.gap;
      end
      if (have_item && idle_left == 0 &&
          !(cur_item.drain && (in_ch.valid || results_due != 0))) begin
        in_ch.valid <= 1'b1;
        in_ch.action <= cur_item.action;
        in_ch.transfer_length <= cur_item.len;
        in_ch.data_byte <= cur_item.data;
        have_item = 1'b0;
      end else begin
        in_ch.valid <= 1'b0;
        if (have_item && idle_left > 0) idle_left--;
      end
    end
  end

  // output backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 25) stall_left = idle_len();
    end
  end

  // monitor, checker and predictor
  always @(posedge clk) begin
    ring_result_t got;
    ring_result_t want;
    int ring_n;
    int used;
    int len;
    int i;
    bit opened;
    if (rst) begin
      rd_idx = 0;
      wr_idx = 0;
      pend_pos = 0;
      bytes_left = 0;
      pend_rejected = 1'b0;
      size_reg = FIFO_SIZE_RST;
      results_due <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.read_byte, out_ch.read_valid, out_ch.last_of_run};
        if (ring_results_due.size() == 0) begin
          $display("%0t unexpected transfer: expected none, got %0d/%02h/%0b/%0b",
                   $realtime, got.status, got.rbyte, got.rvalid, got.last);
          failures++;
        end else begin
          want = ring_results_due.pop_front();
          if (got.status !== want.status || got.rbyte !== want.rbyte ||
              got.rvalid !== want.rvalid || got.last !== want.last) begin
            $display("%0t mismatch: expected %0d/%02h/%0b/%0b, got %0d/%02h/%0b/%0b",
                     $realtime, want.status, want.rbyte, want.rvalid, want.last,
                     got.status, got.rbyte, got.rvalid, got.last);
            failures++;
          end
        end
      end

      if (psel && penable && pwrite && pready &&
          paddr[CFG_ADDR_W-1:2] == REG_FIFO_SIZE) begin
        size_reg = pwdata[SIZE_W-1:0];
        rd_idx = 0;
        wr_idx = 0;
        pend_pos = 0;
        bytes_left = 0;
        pend_rejected = 1'b0;
      end

      if (in_ch.valid && in_ch.ready) begin
        ring_n = clamp_ring(size_reg);
        used = (wr_idx >= rd_idx) ? wr_idx - rd_idx : wr_idx + ring_n - rd_idx;
        len = int'(in_ch.transfer_length);
        if (in_ch.action == ACT_READ) begin
          if (len > MAX_XFER || len > used) begin
            ring_results_due.push_back('{ST_NODATA, 8'h00, 1'b0, 1'b1});
          end else if (len == 0) begin
            ring_results_due.push_back('{ST_OK, 8'h00, 1'b0, 1'b1});
          end else begin
            for (i = 0; i < len; i++) begin
              ring_results_due.push_back('{ST_OK, ring_bytes[rd_idx], 1'b1, i == len - 1});
              rd_idx = (rd_idx + 1 >= ring_n) ? 0 : rd_idx + 1;
            end
          end
        end else begin
          opened = 1'b1;
          if (bytes_left == 0) begin
            if (len == 0) begin
              ring_results_due.push_back('{ST_OK, 8'h00, 1'b0, 1'b1});
              opened = 1'b0;
            end else begin
              pend_rejected = (len > MAX_XFER) || (len > ring_n - 1 - used);
              pend_pos = wr_idx;
              bytes_left = len;
            end
          end
          if (opened) begin
            if (!pend_rejected) begin
              ring_bytes[pend_pos] = in_ch.data_byte;
              pend_pos = (pend_pos + 1 >= ring_n) ? 0 : pend_pos + 1;
            end
            bytes_left--;
            if (bytes_left == 0) begin
              ring_results_due.push_back('{pend_rejected ? ST_NOSPACE : ST_OK,
                                           8'h00, 1'b0, 1'b1});
              if (!pend_rejected) wr_idx = pend_pos;
              pend_rejected = 1'b0;
            end
          end
        end
      end
      results_due <= ring_results_due.size();
    end
  end

  task automatic push_item(input logic act, input logic [LEN_W-1:0] len, input logic [7:0] dat);
    link_item_t it;
    it.action = act;
    it.len = len;
    it.data = dat;
    it.gap = quiet ? 0 : idle_len();
    it.drain = hold_next || ($urandom_range(0, 199) == 0);
    hold_next = 1'b0;
    link_queue.push_back(it);
    items_queued++;
  endtask

  task automatic send_read(input int len);
    push_item(ACT_READ, LEN_W'(len), 8'($urandom_range(0, 255)));
    if (len > 0 && len <= MAX_XFER && len <= gen_held) gen_held -= len;
  endtask

  function automatic int pick_read_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75 && gen_held > 0)
      return $urandom_range(1, gen_held < MAX_XFER ? gen_held : MAX_XFER);
    if (r < 85) return 0;
    return $urandom_range(0, 127);
  endfunction

  task automatic send_write(input int len);
    bit takes;
    int k;
    takes = len != 0 && len <= MAX_XFER && len <= gen_ring - 1 - gen_held;
    if (len == 0) begin
      push_item(ACT_WRITE, '0, 8'($urandom_range(0, 255)));
      return;
    end
    for (k = 0; k < len; k++) begin
      // later bytes may carry a stray length, which must be ignored
      push_item(ACT_WRITE,
                (k > 0 && $urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 127))
                                                    : LEN_W'(len),
                8'($urandom_range(0, 255)));
      if (k < len - 1 && $urandom_range(0, 99) < 6) send_read(pick_read_len());
    end
    if (takes) gen_held += len;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (link_queue.size() != 0 || have_item || in_ch.valid || ring_results_due.size() != 0);
  endtask

  task automatic set_ring_size(input logic [SIZE_W-1:0] sz);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CFG_ADDR_W'(REG_FIFO_SIZE) << 2;
    pwdata <= 32'(sz);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    gen_ring = clamp_ring(sz);
    gen_held = 0;
    @(negedge clk);
  endtask

  initial begin
    logic [SIZE_W-1:0] phase_sizes [8];
    int p;
    int r;
    int target;
    int wl;
    int free;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WRITE;
    in_ch.transfer_length = '0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b1;
    failures = 0;
    cycle_count = 0;
    items_queued = 0;
    quiet = 1'b0;
    hold_next = 1'b0;
    gen_ring = clamp_ring(FIFO_SIZE_RST);
    gen_held = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty ring, zero lengths, stray length, read during open write
    push_item(ACT_READ, 7'd1, 8'h00);
    push_item(ACT_READ, 7'd0, 8'hFF);
    push_item(ACT_WRITE, 7'd0, 8'h77);
    push_item(ACT_WRITE, 7'd3, 8'h00);
    push_item(ACT_WRITE, 7'd127, 8'hFF);
    push_item(ACT_WRITE, 7'd3, 8'hA5);
    hold_next = 1'b1;
    push_item(ACT_READ, 7'd2, 8'h00);
    push_item(ACT_WRITE, 7'd2, 8'h5A);
    push_item(ACT_READ, 7'd1, 8'h00);
    push_item(ACT_WRITE, 7'd2, 8'h3C);
    push_item(ACT_READ, 7'd127, 8'h00);
    push_item(ACT_READ, 7'd3, 8'h00);
    push_item(ACT_READ, 7'd2, 8'h00);
    // left open; the next register write drops it
    push_item(ACT_WRITE, 7'd5, 8'h11);

    // directed: smallest ring
    set_ring_size(11'd2);
    push_item(ACT_WRITE, 7'd2, 8'h01);
    push_item(ACT_WRITE, 7'd2, 8'h02);
    push_item(ACT_WRITE, 7'd1, 8'h81);
    push_item(ACT_WRITE, 7'd1, 8'h18);
    push_item(ACT_READ, 7'd1, 8'h00);

    phase_sizes = '{11'd1024, 11'd2, 11'd0, 11'd2047, 11'd7,
                    11'($urandom_range(3, 64)), 11'($urandom_range(65, 1023)), 11'd1};
    for (p = 0; p < 8; p++) begin
      set_ring_size(phase_sizes[p]);
      quiet = (p == 4);
      if (p == 0) send_write(MAX_XFER + 1);
      target = items_queued + 8;
      if (target < ITEMS_TOTAL * (p + 1) / 8) target = ITEMS_TOTAL * (p + 1) / 8;
      while (items_queued < target) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          free = gen_ring - 1 - gen_held;
          r = $urandom_range(0, 99);
          if (r < 80 && free > 0) wl = $urandom_range(1, free < MAX_XFER ? free : MAX_XFER);
          else if (r < 94) wl = $urandom_range(1, MAX_XFER);
          else if (r < 98) wl = 0;
          else wl = $urandom_range(MAX_XFER + 1, MAX_XFER + 12);
          send_write(wl);
        end else if (r < 92) begin
          send_read(pick_read_len());
        end else begin
          send_read($urandom_range(0, 127));
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### ring_buffer_block_transfer.f
sv/rbt_pkg.sv
sv/rbt_in_if.sv
sv/rbt_out_if.sv
sv/rbt_ctrl.sv
sv/rbt_datapath.sv
sv/ring_buffer_block_transfer.sv
sv/rbt_checker.sv
dv/ring_buffer_block_transfer_tb.sv
